// File: sv/assert_macros.svh
// Assertion macros used by the ALU RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a consequence in the same cycle as its cause.
`define ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Check a consequence in the cycle after its cause.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// File: sv/ebalu_pkg.sv
// Shared types and constants of the eight-bit ALU.
`default_nettype none

package ebalu_pkg;

   // Operation codes carried in the opcode field
   typedef enum logic [4:0] {
      OP_INC8  = 5'd0,
      OP_DEC8  = 5'd1,
      OP_ADD   = 5'd2,
      OP_ADC   = 5'd3,
      OP_SUB   = 5'd4,
      OP_SBC   = 5'd5,
      OP_AND   = 5'd6,
      OP_OR    = 5'd7,
      OP_XOR   = 5'd8,
      OP_CP    = 5'd9,
      OP_INC16 = 5'd10,
      OP_DEC16 = 5'd11,
      OP_ADD16 = 5'd12,
      OP_ADDSP = 5'd13,
      OP_DAA   = 5'd14,
      OP_SCF   = 5'd15,
      OP_CPL   = 5'd16,
      OP_CCF   = 5'd17
   } op_type;

   // Flag bit positions
   localparam int FLAG_Z = 3;
   localparam int FLAG_N = 2;
   localparam int FLAG_H = 1;
   localparam int FLAG_C = 0;

   // Decimal adjust constants
   localparam logic [7:0] DAA_LOW_FIX  = 8'h06;
   localparam logic [7:0] DAA_HIGH_FIX = 8'h60;
   localparam logic [7:0] DAA_MAX_BCD  = 8'h99;
   localparam logic [3:0] DAA_MAX_DIGIT = 4'h9;

   // Input stage payload
   typedef struct packed {
      logic [4:0]  op;
      logic [7:0]  acc;
      logic [3:0]  flags;
      logic [7:0]  op8;
      logic [15:0] wa;
      logic [15:0] wb;
   } s1_type;

   // Arithmetic stage payload
   typedef struct packed {
      logic [4:0]  op;
      logic [7:0]  acc;
      logic [3:0]  flags;
      logic [7:0]  alu8;
      logic        half;
      logic        carry;
      logic [7:0]  byte_res;
      logic [15:0] word_res;
   } s2_type;

   // Output stage payload
   typedef struct packed {
      logic [7:0]  acc;
      logic [3:0]  flags;
      logic [7:0]  byte_res;
      logic [15:0] word_res;
   } s3_type;

endpackage

`default_nettype wire

// File: sv/ebalu_daa.sv
// Decimal adjust of the accumulator after a BCD add or subtract.
`default_nettype none

module ebalu_daa (
   input  logic [7:0] acc_in,
   input  logic [3:0] flags_in,
   output logic [7:0] acc_out,
   output logic [3:0] flags_out
);
   import ebalu_pkg::*;

   logic       fix_low;
   logic       fix_high;
   logic [7:0] corr;
   logic       carry_out;

   // Pick the correction from the unadjusted value and the flags
   always_comb begin
      if (!flags_in[FLAG_N]) begin
         fix_low  = flags_in[FLAG_H] || (acc_in[3:0] > DAA_MAX_DIGIT);
         fix_high = flags_in[FLAG_C] || (acc_in > DAA_MAX_BCD);
      end else begin
         fix_low  = flags_in[FLAG_H];
         fix_high = flags_in[FLAG_C];
      end
      corr = (fix_low ? DAA_LOW_FIX : 8'h00) | (fix_high ? DAA_HIGH_FIX : 8'h00);
      carry_out = flags_in[FLAG_C] || (!flags_in[FLAG_N] && fix_high);
      acc_out = flags_in[FLAG_N] ? (acc_in - corr) : (acc_in + corr);
   end

   // Z from the result, N kept, H cleared, C from the adjust
   always_comb begin
      flags_out         = 4'h0;
      flags_out[FLAG_Z] = (acc_out == 8'h00);
      flags_out[FLAG_N] = flags_in[FLAG_N];
      flags_out[FLAG_H] = 1'b0;
      flags_out[FLAG_C] = carry_out;
   end

endmodule

`default_nettype wire

// File: sv/eight_bit_alu_with_flags.sv
// Path: an input transfer is registered in operand capture, then in the adder stage,
// then in the flag and decimal-adjust stage, whose register drives the response.
// Throughput: one operation per cycle; the three stage registers (operand
// capture, adders, flag and decimal-adjust logic) each take a new item every
// cycle and hold it while the stage after them is full and stalled.
// Reset: synchronous, active high; clears the stage valid bits only.
`default_nettype none

module eight_bit_alu_with_flags (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // opcode[4:0], acc_in[12:5], flags_in[16:13], operand8[24:17],
   // word_a[40:25], word_b[56:41], zero fill[63:57]
   input  logic [63:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // acc_out[7:0], flags_out[11:8], byte_out[19:12], word_out[35:20],
   // zero fill[39:36]
   output logic [39:0] rsp_tdata
);
   import ebalu_pkg::*;
   `include "assert_macros.svh"

   logic   v1_ff, v2_ff, v3_ff;
   logic   rdy1, rdy2, rdy3;
   s1_type s1_ff, s1_in;
   s2_type s2_ff, s2_in;
   s3_type s3_ff, s3_in;

   // A stage moves on when it is empty or the next one moves on
   assign rdy3       = !v3_ff || rsp_tready;
   assign rdy2       = !v2_ff || rdy3;
   assign rdy1       = !v1_ff || rdy2;
   assign req_tready = rdy1;
   assign rsp_tvalid = v3_ff;
   assign rsp_tdata  = {4'h0, s3_ff.word_res, s3_ff.byte_res, s3_ff.flags, s3_ff.acc};

   // Unpack the input transfer
   always_comb begin
      s1_in.op    = req_tdata[4:0];
      s1_in.acc   = req_tdata[12:5];
      s1_in.flags = req_tdata[16:13];
      s1_in.op8   = req_tdata[24:17];
      s1_in.wa    = req_tdata[40:25];
      s1_in.wb    = req_tdata[56:41];
   end

   // Stage one: all adders side by side, then pick by operation
   logic       cin;
   logic [8:0] add9, sub9;
   logic [4:0] addh, subh, sph;
   logic [16:0] w17;
   logic [12:0] w13;
   logic [15:0] sp_sum;
   logic [8:0] spc;

   always_comb begin
      cin  = ((s1_ff.op == OP_ADC) || (s1_ff.op == OP_SBC)) && s1_ff.flags[FLAG_C];
      add9 = {1'b0, s1_ff.acc} + {1'b0, s1_ff.op8} + {8'h00, cin};
      addh = {1'b0, s1_ff.acc[3:0]} + {1'b0, s1_ff.op8[3:0]} + {4'h0, cin};
      sub9 = {1'b0, s1_ff.acc} - {1'b0, s1_ff.op8} - {8'h00, cin};
      subh = {1'b0, s1_ff.acc[3:0]} - {1'b0, s1_ff.op8[3:0]} - {4'h0, cin};
      w17  = {1'b0, s1_ff.wa} + {1'b0, s1_ff.wb};
      w13  = {1'b0, s1_ff.wa[11:0]} + {1'b0, s1_ff.wb[11:0]};
      sp_sum = s1_ff.wa + {{8{s1_ff.op8[7]}}, s1_ff.op8};
      sph  = {1'b0, s1_ff.wa[3:0]} + {1'b0, s1_ff.op8[3:0]};
      spc  = {1'b0, s1_ff.wa[7:0]} + {1'b0, s1_ff.op8};

      s2_in.op       = s1_ff.op;
      s2_in.acc      = s1_ff.acc;
      s2_in.flags    = s1_ff.flags;
      s2_in.alu8     = s1_ff.acc;
      s2_in.half     = 1'b0;
      s2_in.carry    = 1'b0;
      s2_in.byte_res = 8'h00;
      s2_in.word_res = 16'h0000;
      unique case (s1_ff.op)
         OP_INC8: begin
            s2_in.byte_res = s1_ff.op8 + 8'h01;
            s2_in.half     = (s1_ff.op8[3:0] == 4'hF);
         end
         OP_DEC8: begin
            s2_in.byte_res = s1_ff.op8 - 8'h01;
            s2_in.half     = (s1_ff.op8[3:0] == 4'h0);
         end
         OP_ADD, OP_ADC: begin
            s2_in.alu8  = add9[7:0];
            s2_in.half  = addh[4];
            s2_in.carry = add9[8];
         end
         OP_SUB, OP_SBC, OP_CP: begin
            s2_in.alu8  = sub9[7:0];
            s2_in.half  = subh[4];
            s2_in.carry = sub9[8];
         end
         OP_AND: s2_in.alu8 = s1_ff.acc & s1_ff.op8;
         OP_OR:  s2_in.alu8 = s1_ff.acc | s1_ff.op8;
         OP_XOR: s2_in.alu8 = s1_ff.acc ^ s1_ff.op8;
         OP_INC16: s2_in.word_res = s1_ff.wa + 16'h0001;
         OP_DEC16: s2_in.word_res = s1_ff.wa - 16'h0001;
         OP_ADD16: begin
            s2_in.word_res = w17[15:0];
            s2_in.half     = w13[12];
            s2_in.carry    = w17[16];
         end
         OP_ADDSP: begin
            s2_in.word_res = sp_sum;
            s2_in.half     = sph[4];
            s2_in.carry    = spc[8];
         end
         OP_CPL: s2_in.alu8 = ~s1_ff.acc;
         default: ;
      endcase
   end

   // Stage two: decimal adjust, zero detect and flag assembly
   logic [7:0] daa_acc;
   logic [3:0] daa_flags;
   logic [3:0] f2;

   ebalu_daa u_daa (
      .acc_in    (s2_ff.acc),
      .flags_in  (s2_ff.flags),
      .acc_out   (daa_acc),
      .flags_out (daa_flags)
   );

   always_comb begin
      f2             = s2_ff.flags;
      s3_in.acc      = s2_ff.acc;
      s3_in.byte_res = s2_ff.byte_res;
      s3_in.word_res = s2_ff.word_res;
      unique case (s2_ff.op)
         OP_INC8, OP_DEC8: begin
            f2[FLAG_Z] = (s2_ff.byte_res == 8'h00);
            f2[FLAG_N] = (s2_ff.op == OP_DEC8);
            f2[FLAG_H] = s2_ff.half;
         end
         OP_ADD, OP_ADC, OP_SUB, OP_SBC, OP_CP: begin
            f2[FLAG_Z] = (s2_ff.alu8 == 8'h00);
            f2[FLAG_N] = (s2_ff.op != OP_ADD) && (s2_ff.op != OP_ADC);
            f2[FLAG_H] = s2_ff.half;
            f2[FLAG_C] = s2_ff.carry;
            if (s2_ff.op != OP_CP) begin
               s3_in.acc = s2_ff.alu8;
            end
         end
         OP_AND, OP_OR, OP_XOR: begin
            s3_in.acc  = s2_ff.alu8;
            f2         = 4'h0;
            f2[FLAG_Z] = (s2_ff.alu8 == 8'h00);
            f2[FLAG_H] = (s2_ff.op == OP_AND);
         end
         OP_ADD16: begin
            f2[FLAG_N] = 1'b0;
            f2[FLAG_H] = s2_ff.half;
            f2[FLAG_C] = s2_ff.carry;
         end
         OP_ADDSP: begin
            f2         = 4'h0;
            f2[FLAG_H] = s2_ff.half;
            f2[FLAG_C] = s2_ff.carry;
         end
         OP_DAA: begin
            s3_in.acc = daa_acc;
            f2        = daa_flags;
         end
         OP_SCF, OP_CCF: begin
            f2[FLAG_N] = 1'b0;
            f2[FLAG_H] = 1'b0;
            f2[FLAG_C] = (s2_ff.op == OP_SCF) || !s2_ff.flags[FLAG_C];
         end
         OP_CPL: begin
            s3_in.acc  = s2_ff.alu8;
            f2[FLAG_N] = 1'b1;
            f2[FLAG_H] = 1'b1;
         end
         default: ;
      endcase
      s3_in.flags = f2;
   end

   // Advance the valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_tvalid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
      end
   end

   // Advance the payloads; a stalled stage holds
   always_ff @(posedge clock) begin
      if (rdy1 && req_tvalid) s1_ff <= s1_in;
      if (rdy2 && v1_ff)      s2_ff <= s2_in;
      if (rdy3 && v2_ff)      s3_ff <= s3_in;
   end

   // An input transfer lands in stage one
   `ASSERT_NEXT(a_accept_fills_s1, clock, reset, req_tvalid && req_tready, v1_ff)
   // A full stage behind a stalled output keeps its item
   `ASSERT_NEXT(a_stall_keeps_s2, clock, reset, v2_ff && v3_ff && !rsp_tready, v2_ff)
   // Back pressure reaches the input only with every stage full
   `ASSERT_NOW(a_full_when_blocked, clock, reset, !req_tready, v1_ff && v2_ff && v3_ff)

endmodule

`default_nettype wire

// File: sim/tb_eight_bit_alu_with_flags.sv
// Self-checking testbench of the eight-bit ALU: random and corner operations against a predictor.
`timescale 1ns / 1ps

module tb_eight_bit_alu_with_flags;
   import ebalu_pkg::*;

   // Opcodes beyond the defined set act as no operation
   localparam logic [4:0] OP_UNDEF_LO = 5'd18;
   localparam logic [4:0] OP_UNDEF_HI = 5'd31;

   localparam int ITEMS_PER_PHASE = 313;
   localparam int LONG_HOLD       = 200;
   localparam int DRAIN_CYCLES    = 8;
   localparam int CYCLE_LIMIT     = 200000;

   typedef struct {
      logic [4:0]  opcode;
      logic [7:0]  acc_in;
      logic [3:0]  flags_in;
      logic [7:0]  operand8;
      logic [15:0] word_a;
      logic [15:0] word_b;
   } alu_op_type;

   typedef struct {
      logic [7:0]  acc_out;
      logic [3:0]  flags_out;
      logic [7:0]  byte_out;
      logic [15:0] word_out;
   } alu_res_type;

   // Predict ALU results and compare them with what the block returns
   class alu_scoreboard_type;
      alu_res_type pending_results[$];
      int unsigned mismatches;

      function alu_res_type predict_alu(alu_op_type it);
         alu_res_type res;
         logic [7:0]  a;
         logic [3:0]  f;
         logic        cin;
         logic [7:0]  r;
         logic [4:0]  h5;
         logic [8:0]  s9;
         logic [12:0] h13;
         logic [16:0] s17;
         logic [7:0]  corr;
         a = it.acc_in;
         f = it.flags_in;
         cin = 1'b0;
         corr = 8'h00;
         res.byte_out = 8'h00;
         res.word_out = 16'h0000;
         case (it.opcode)
            OP_INC8: begin
               r = it.operand8 + 8'd1;
               res.byte_out = r;
               f[FLAG_Z] = (r == 8'h00);
               f[FLAG_N] = 1'b0;
               f[FLAG_H] = (it.operand8[3:0] == 4'hF);
            end
            OP_DEC8: begin
               r = it.operand8 - 8'd1;
               res.byte_out = r;
               f[FLAG_Z] = (r == 8'h00);
               f[FLAG_N] = 1'b1;
               f[FLAG_H] = (it.operand8[3:0] == 4'h0);
            end
            OP_ADD, OP_ADC: begin
               if (it.opcode == OP_ADC) cin = f[FLAG_C];
               s9 = {1'b0, a} + {1'b0, it.operand8} + cin;
               h5 = {1'b0, a[3:0]} + {1'b0, it.operand8[3:0]} + cin;
               f[FLAG_Z] = (s9[7:0] == 8'h00);
               f[FLAG_N] = 1'b0;
               f[FLAG_H] = h5[4];
               f[FLAG_C] = s9[8];
               a = s9[7:0];
            end
            OP_SUB, OP_SBC, OP_CP: begin
               if (it.opcode == OP_SBC) cin = f[FLAG_C];
               r = a - it.operand8 - cin;
               f[FLAG_Z] = (r == 8'h00);
               f[FLAG_N] = 1'b1;
               f[FLAG_H] = ({1'b0, a[3:0]} < ({1'b0, it.operand8[3:0]} + cin));
               f[FLAG_C] = ({1'b0, a} < ({1'b0, it.operand8} + cin));
               if (it.opcode != OP_CP) a = r;
            end
            OP_AND, OP_OR, OP_XOR: begin
               if (it.opcode == OP_AND) a = a & it.operand8;
               else if (it.opcode == OP_OR) a = a | it.operand8;
               else a = a ^ it.operand8;
               f = 4'h0;
               f[FLAG_Z] = (a == 8'h00);
               f[FLAG_H] = (it.opcode == OP_AND);
            end
            OP_INC16: res.word_out = it.word_a + 16'd1;
            OP_DEC16: res.word_out = it.word_a - 16'd1;
            OP_ADD16: begin
               s17 = {1'b0, it.word_a} + {1'b0, it.word_b};
               h13 = {1'b0, it.word_a[11:0]} + {1'b0, it.word_b[11:0]};
               res.word_out = s17[15:0];
               f[FLAG_N] = 1'b0;
               f[FLAG_H] = h13[12];
               f[FLAG_C] = s17[16];
            end
            OP_ADDSP: begin
               res.word_out = it.word_a + {{8{it.operand8[7]}}, it.operand8};
               h5 = {1'b0, it.word_a[3:0]} + {1'b0, it.operand8[3:0]};
               s9 = {1'b0, it.word_a[7:0]} + {1'b0, it.operand8};
               f = 4'h0;
               f[FLAG_H] = h5[4];
               f[FLAG_C] = s9[8];
            end
            OP_DAA: begin
               // Correction depends on the unadjusted accumulator
               if (!f[FLAG_N]) begin
                  if (f[FLAG_H] || (a[3:0] > DAA_MAX_DIGIT)) corr = corr | DAA_LOW_FIX;
                  if (f[FLAG_C] || (a > DAA_MAX_BCD)) begin
                     corr = corr | DAA_HIGH_FIX;
                     f[FLAG_C] = 1'b1;
                  end
                  a = a + corr;
               end else begin
                  if (f[FLAG_H]) corr = corr | DAA_LOW_FIX;
                  if (f[FLAG_C]) corr = corr | DAA_HIGH_FIX;
                  a = a - corr;
               end
               f[FLAG_Z] = (a == 8'h00);
               f[FLAG_H] = 1'b0;
            end
            OP_SCF: begin
               f[FLAG_N] = 1'b0;
               f[FLAG_H] = 1'b0;
               f[FLAG_C] = 1'b1;
            end
            OP_CPL: begin
               a = ~a;
               f[FLAG_N] = 1'b1;
               f[FLAG_H] = 1'b1;
            end
            OP_CCF: begin
               f[FLAG_N] = 1'b0;
               f[FLAG_H] = 1'b0;
               f[FLAG_C] = ~f[FLAG_C];
            end
            default: ;
         endcase
         res.acc_out = a;
         res.flags_out = f;
         return res;
      endfunction

      function void note_input(alu_op_type it);
         pending_results.push_back(predict_alu(it));
      endfunction

      function void check_result(alu_res_type got);
         alu_res_type want;
         if (pending_results.size() == 0) begin
            $error("result with nothing outstanding: acc_out %h flags_out %h",
                   got.acc_out, got.flags_out);
            mismatches++;
            return;
         end
         want = pending_results.pop_front();
         if (got.acc_out !== want.acc_out) begin
            $error("acc_out: expected %h, actual %h", want.acc_out, got.acc_out);
            mismatches++;
         end
         if (got.flags_out !== want.flags_out) begin
            $error("flags_out: expected %h, actual %h", want.flags_out, got.flags_out);
            mismatches++;
         end
         if (got.byte_out !== want.byte_out) begin
            $error("byte_out: expected %h, actual %h", want.byte_out, got.byte_out);
            mismatches++;
         end
         if (got.word_out !== want.word_out) begin
            $error("word_out: expected %h, actual %h", want.word_out, got.word_out);
            mismatches++;
         end
      endfunction

      function int pending();
         return pending_results.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;

   alu_scoreboard_type board;
   int unsigned   sender_idle_pct;
   int unsigned   receiver_stall_pct;
   bit            hold_req;
   int unsigned   hold_left;
   int unsigned   cycle_count;

   eight_bit_alu_with_flags i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic alu_op_type make_op(logic [4:0] opcode, logic [7:0] acc,
                                          logic [3:0] flags, logic [7:0] op8,
                                          logic [15:0] wa, logic [15:0] wb);
      alu_op_type it;
      it.opcode = opcode;
      it.acc_in = acc;
      it.flags_in = flags;
      it.operand8 = op8;
      it.word_a = wa;
      it.word_b = wb;
      return it;
   endfunction

   // Bias bytes toward the carry and borrow boundaries
   function automatic logic [7:0] rand_byte();
      logic [31:0] r;
      r = $urandom;
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hFF;
         2: return {r[7:4], 4'hF};
         3: return {r[7:4], 4'h0};
         default: return r[7:0];
      endcase
   endfunction

   function automatic logic [15:0] rand_word();
      logic [31:0] r;
      r = $urandom;
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return {r[15:12], 12'hFFF};
         3: return {r[15:8], 8'hFF};
         default: return r[15:0];
      endcase
   endfunction

   function automatic alu_op_type rand_op();
      logic [4:0] opcode;
      logic [3:0] flags;
      if ($urandom_range(0, 99) < 6) opcode = 5'($urandom_range(OP_UNDEF_HI, OP_UNDEF_LO));
      else opcode = 5'($urandom_range(OP_CCF, OP_INC8));
      flags = 4'($urandom_range(0, 15));
      return make_op(opcode, rand_byte(), flags, rand_byte(), rand_word(), rand_word());
   endfunction

   // Offer one operation, after a random gap, and hold it until the transfer
   task automatic send_op(alu_op_type it);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'b0, it.word_b, it.word_a, it.operand8, it.flags_in, it.acc_in,
                     it.opcode};
      do @(posedge clock); while (!req_tready);
      board.note_input(it);
   endtask

   // Stop offering until every outstanding result has come back
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (board.pending() != 0) @(posedge clock);
   endtask

   // Receive results, with random stalls and an occasional long hold-off
   always @(posedge clock) begin
      alu_res_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.acc_out   = rsp_tdata[7:0];
         got.flags_out = rsp_tdata[11:8];
         got.byte_out  = rsp_tdata[19:12];
         got.word_out  = rsp_tdata[35:20];
         board.check_result(got);
      end
      if (hold_req && hold_left == 0) begin
         hold_left = LONG_HOLD;
         hold_req = 1'b0;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
      end
   end

   // End the run if it takes far longer than the slowest correct run
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb: failure");
      $finish;
   end

   initial begin
      alu_op_type corner_ops[$];
      int unsigned idle_by_phase[4];
      int unsigned stall_by_phase[4];
      board = new();
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      rsp_tready = 1'b0;
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      hold_req = 1'b0;
      hold_left = 0;
      idle_by_phase  = '{0, 66, 0, 9};
      stall_by_phase = '{0, 0, 66, 9};

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Corner cases: wrap of every adder, both decimal adjust paths, no-op codes
      corner_ops.push_back(make_op(OP_INC8,  8'h00, 4'h0, 8'hFF, 16'h0000, 16'h0000));
      corner_ops.push_back(make_op(OP_INC8,  8'hFF, 4'hF, 8'h0F, 16'hFFFF, 16'hFFFF));
      corner_ops.push_back(make_op(OP_DEC8,  8'h00, 4'h0, 8'h00, 16'h0000, 16'h0000));
      corner_ops.push_back(make_op(OP_DEC8,  8'hFF, 4'hF, 8'h01, 16'h0000, 16'h0000));
      corner_ops.push_back(make_op(OP_ADD,   8'hFF, 4'h1, 8'h01, 16'h0000, 16'h0000));
      corner_ops.push_back(make_op(OP_ADC,   8'h0F, 4'h1, 8'hF0, 16'h0000, 16'h0000));
      corner_ops.push_back(make_op(OP_SUB,   8'h00, 4'h0, 8'h01, 16'h0000, 16'h0000));
      corner_ops.push_back(make_op(OP_SBC,   8'h10, 4'h1, 8'h0F, 16'h0000, 16'h0000));
      corner_ops.push_back(make_op(OP_SBC,   8'hFF, 4'h1, 8'hFF, 16'h0000, 16'h0000));
      corner_ops.push_back(make_op(OP_CP,    8'h42, 4'h0, 8'h42, 16'h0000, 16'h0000));
      corner_ops.push_back(make_op(OP_AND,   8'hF0, 4'hF, 8'h0F, 16'h0000, 16'h0000));
      corner_ops.push_back(make_op(OP_OR,    8'hFF, 4'h0, 8'hFF, 16'h0000, 16'h0000));
      corner_ops.push_back(make_op(OP_XOR,   8'hA5, 4'hF, 8'hA5, 16'h0000, 16'h0000));
      corner_ops.push_back(make_op(OP_INC16, 8'h00, 4'hF, 8'h00, 16'hFFFF, 16'h0000));
      corner_ops.push_back(make_op(OP_DEC16, 8'hFF, 4'h0, 8'h00, 16'h0000, 16'hFFFF));
      corner_ops.push_back(make_op(OP_ADD16, 8'h00, 4'h8, 8'h00, 16'h0FFF, 16'h0001));
      corner_ops.push_back(make_op(OP_ADD16, 8'h00, 4'h4, 8'h00, 16'hFFFF, 16'hFFFF));
      corner_ops.push_back(make_op(OP_ADDSP, 8'h00, 4'hF, 8'h80, 16'hFFFF, 16'h0000));
      corner_ops.push_back(make_op(OP_ADDSP, 8'h00, 4'h0, 8'h01, 16'h00FF, 16'h0000));
      corner_ops.push_back(make_op(OP_DAA,   8'h9A, 4'h0, 8'h00, 16'h0000, 16'h0000));
      corner_ops.push_back(make_op(OP_DAA,   8'h00, 4'h7, 8'h00, 16'h0000, 16'h0000));
      corner_ops.push_back(make_op(OP_DAA,   8'h66, 4'h6, 8'h00, 16'h0000, 16'h0000));
      corner_ops.push_back(make_op(OP_SCF,   8'h00, 4'hE, 8'h00, 16'h0000, 16'h0000));
      corner_ops.push_back(make_op(OP_CPL,   8'h00, 4'h9, 8'h00, 16'h0000, 16'h0000));
      corner_ops.push_back(make_op(OP_CCF,   8'hFF, 4'hF, 8'hFF, 16'hFFFF, 16'hFFFF));
      corner_ops.push_back(make_op(OP_UNDEF_LO, 8'h5A, 4'hA, 8'hFF, 16'hFFFF, 16'hFFFF));
      corner_ops.push_back(make_op(OP_UNDEF_HI, 8'hFF, 4'hF, 8'hFF, 16'hFFFF, 16'hFFFF));
      foreach (corner_ops[i]) send_op(corner_ops[i]);
      drain();

      // Random phases; the first starts with a long receiver hold-off
      for (int p = 0; p < 4; p++) begin
         sender_idle_pct = idle_by_phase[p];
         receiver_stall_pct = stall_by_phase[p];
         if (p == 0) hold_req = 1'b1;
         for (int n = 0; n < ITEMS_PER_PHASE; n++) send_op(rand_op());
         drain();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.mismatches == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end

endmodule

// File: sim.f
+incdir+sv
sv/ebalu_pkg.sv
sv/ebalu_daa.sv
sv/eight_bit_alu_with_flags.sv
sim/tb_eight_bit_alu_with_flags.sv
